@@ sv/bqsf_pkg.sv @@
// Shared constants and register codes for the bit-quad shape feature core.
`default_nettype none
package bqsf_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int COUNT_BITS_DEF = 18;

  localparam int PIXEL_W     = 8;
  localparam int ROW_WIDTH_W = 10;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 10;

  localparam int IN_TDATA_W = 8;

  localparam int CNT_FIELD_W   = 18;
  localparam int AREA_FIELD_W  = 21;
  localparam int PERIM_FIELD_W = 35;
  localparam int EULER_FIELD_W = 20;
  localparam int OUT_FIELDS_W  = 5 * CNT_FIELD_W + AREA_FIELD_W + PERIM_FIELD_W
                                 + EULER_FIELD_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // 65536 / sqrt(2), rounded
  localparam int unsigned INV_SQRT2_Q16 = 46341;
  localparam int          FRAC_BITS     = 16;

  localparam int EULER_MAX = 524287;
  localparam int EULER_MIN = -524288;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ROW_WIDTH      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DARK_THRESHOLD = 2'd1;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST      = 10'd256;
  localparam logic [PIXEL_W-1:0]     DARK_THRESHOLD_RST = 8'd50;

  // counter slots
  localparam int Q_ONE   = 0;
  localparam int Q_TWO   = 1;
  localparam int Q_THREE = 2;
  localparam int Q_FOUR  = 3;
  localparam int Q_DIAG  = 4;
  localparam int Q_NUM   = 5;

endpackage
`default_nettype wire

@@ sv/bit_quad_shape_features_core.sv @@
// Bit-quad shape features: streaming 2x2 window counter with area, perimeter, Euler.
// Throughput: one pixel beat per cycle; input stalls only while both result stages
//   are full and the sink holds off.
// Result path: a tlast beat fills the snapshot stage, then the result register.
// Reset: counters, column, row flag and neighbor bits clear; row_width = 256,
//   dark_threshold = 50; line buffer columns at or above the fill mark read as zero.
`default_nettype none
module bit_quad_shape_features_core #(
  parameter int MAX_WIDTH  = bqsf_pkg::MAX_WIDTH_DEF,
  parameter int COUNT_BITS = bqsf_pkg::COUNT_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration write channel
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [bqsf_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [bqsf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // pixel stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [bqsf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] pixel
  input  wire logic                             s_axis_tlast,
  // result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [17:0] count_one, [35:18] count_two_adjacent, [53:36] count_three,
  // [71:54] count_four, [89:72] count_diagonal, [110:90] area_eighths,
  // [145:111] perimeter_q16, [165:146] euler_quarters, [167:166] zero
  output logic [bqsf_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);
  import bqsf_pkg::*;

  localparam int CB    = COUNT_BITS;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WW    = (COL_W + 1 > ROW_WIDTH_W) ? COL_W + 1 : ROW_WIDTH_W;
  localparam int SW    = CB + 2;                       // c1 + c3 + 2*cd
  localparam int MW    = SW + FRAC_BITS;
  localparam int AW    = (CB + 5 > AREA_FIELD_W) ? CB + 5 : AREA_FIELD_W;
  localparam int PW    = (CB + 19 > PERIM_FIELD_W) ? CB + 19 : PERIM_FIELD_W;
  localparam int EW    = (CB + 3 > EULER_FIELD_W) ? CB + 3 : EULER_FIELD_W;

  localparam logic [AW-1:0]        AREA_SAT  = AW'({AREA_FIELD_W{1'b1}});
  localparam logic [PW-1:0]        PERIM_SAT = PW'({PERIM_FIELD_W{1'b1}});
  localparam logic signed [EW-1:0] EUL_HI    = EW'(EULER_MAX);
  localparam logic signed [EW-1:0] EUL_LO    = EW'(EULER_MIN);

  // ---------------------------------------------------------------- config
  logic [ROW_WIDTH_W-1:0] row_width_q;
  logic [PIXEL_W-1:0]     dark_thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RST;
      dark_thr_q  <= DARK_THRESHOLD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_ROW_WIDTH:      row_width_q <= cfg_data_i[ROW_WIDTH_W-1:0];
        CFG_DARK_THRESHOLD: dark_thr_q  <= cfg_data_i[PIXEL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  logic s1_valid_q, out_valid_q;
  logic out_ready, s1_ready, in_acc;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s1_ready      = !s1_valid_q || out_ready;
  assign s_axis_tready = s1_ready;
  assign in_acc        = s_axis_tvalid && s1_ready;

  // ---------------------------------------------------------------- window
  logic [COL_W-1:0] col_q, col_d;
  logic             row_done_q;
  logic             left_q, ul_q, up_q;
  logic             up_ok_q, up_bit;
  logic [COL_W:0]   fill_q;
  logic             dark;
  logic [WW-1:0]    w_ext, w_eff;
  logic [COL_W:0]   col_inc;
  logic             wrap;

  assign dark    = s_axis_tdata[PIXEL_W-1:0] <= dark_thr_q;
  assign w_ext   = WW'(row_width_q);
  assign col_inc = {1'b0, col_q} + 1'b1;
  assign wrap    = WW'(col_inc) >= w_eff;

  always_comb begin
    if (w_ext < WW'(2)) begin
      w_eff = WW'(2);
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
  end

  always_comb begin
    col_d = col_q;
    if (in_acc) begin
      if (s_axis_tlast || wrap) begin
        col_d = '0;
      end else begin
        col_d = col_inc[COL_W-1:0];
      end
    end
  end

  // line buffer: read one column ahead so the bit above is registered in time
  logic line_mem [MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      line_mem[col_q] <= dark;
    end
    up_q <= line_mem[col_d];
  end

  // columns are written in order from zero, so everything below the fill mark holds data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      up_ok_q <= 1'b0;
    end else begin
      up_ok_q <= {1'b0, col_d} < fill_q;
      if (in_acc && col_inc > fill_q) begin
        fill_q <= col_inc;
      end
    end
  end

  assign up_bit = up_q && up_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_done_q <= 1'b0;
      left_q     <= 1'b0;
      ul_q       <= 1'b0;
    end else if (in_acc) begin
      col_q <= col_d;
      if (s_axis_tlast) begin
        row_done_q <= 1'b0;
        left_q     <= 1'b0;
        ul_q       <= 1'b0;
      end else begin
        row_done_q <= row_done_q || wrap;
        left_q     <= dark;
        ul_q       <= up_bit;
      end
    end
  end

  // ---------------------------------------------------------------- classify
  logic [Q_NUM-1:0] inc;
  logic [2:0]       n_dark;

  assign n_dark = 3'(ul_q) + 3'(up_bit) + 3'(left_q) + 3'(dark);

  always_comb begin
    inc = '0;
    if (row_done_q && col_q != '0) begin
      case (n_dark)
        3'd1: inc[Q_ONE] = 1'b1;
        3'd2: begin
          // equal corners on one diagonal means the pair lies on a diagonal
          if (ul_q == dark) inc[Q_DIAG] = 1'b1;
          else              inc[Q_TWO]  = 1'b1;
        end
        3'd3: inc[Q_THREE] = 1'b1;
        3'd4: inc[Q_FOUR]  = 1'b1;
        default: ;
      endcase
    end
  end

  logic [CB-1:0] cnt_q [Q_NUM];
  logic [CB-1:0] cnt_d [Q_NUM];
  logic [CB-1:0] snap_q [Q_NUM];

  always_comb begin
    for (int k = 0; k < Q_NUM; k++) begin
      cnt_d[k] = cnt_q[k];
      if (inc[k] && cnt_q[k] != '1) cnt_d[k] = cnt_q[k] + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Q_NUM; k++) cnt_q[k] <= '0;
    end else if (in_acc) begin
      for (int k = 0; k < Q_NUM; k++) cnt_q[k] <= s_axis_tlast ? '0 : cnt_d[k];
    end
  end

  // ---------------------------------------------------------------- snapshot stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_acc && s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tlast) begin
      for (int k = 0; k < Q_NUM; k++) snap_q[k] <= cnt_d[k];
    end
  end

  // ---------------------------------------------------------------- derived measures
  logic [SW-1:0]        sum_odd;
  logic [MW-1:0]        prod;
  logic [PW-1:0]        perim, perim_sat;
  logic [AW-1:0]        area, area_sat;
  logic signed [EW-1:0] eul, eul_sat;

  assign sum_odd = SW'(snap_q[Q_ONE]) + SW'(snap_q[Q_THREE])
                 + (SW'(snap_q[Q_DIAG]) << 1);
  assign prod    = MW'(sum_odd) * MW'(INV_SQRT2_Q16);
  assign perim   = PW'(prod) + (PW'(snap_q[Q_TWO]) << FRAC_BITS);
  assign area    = (AW'(snap_q[Q_ONE]) << 1) + (AW'(snap_q[Q_TWO]) << 2)
                 + (AW'(snap_q[Q_THREE]) * AW'(7)) + (AW'(snap_q[Q_FOUR]) << 3)
                 + (AW'(snap_q[Q_DIAG]) * AW'(6));
  assign eul     = EW'(snap_q[Q_ONE]) - EW'(snap_q[Q_THREE])
                 - (EW'(snap_q[Q_DIAG]) << 1);

  assign perim_sat = (perim > PERIM_SAT) ? PERIM_SAT : perim;
  assign area_sat  = (area > AREA_SAT) ? AREA_SAT : area;

  always_comb begin
    if (eul > EUL_HI) begin
      eul_sat = EUL_HI;
    end else if (eul < EUL_LO) begin
      eul_sat = EUL_LO;
    end else begin
      eul_sat = eul;
    end
  end

  // ---------------------------------------------------------------- result register
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  assign out_data_d = {
    {(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
    eul_sat[EULER_FIELD_W-1:0],
    perim_sat[PERIM_FIELD_W-1:0],
    area_sat[AREA_FIELD_W-1:0],
    CNT_FIELD_W'(snap_q[Q_DIAG]),
    CNT_FIELD_W'(snap_q[Q_FOUR]),
    CNT_FIELD_W'(snap_q[Q_THREE]),
    CNT_FIELD_W'(snap_q[Q_TWO]),
    CNT_FIELD_W'(snap_q[Q_ONE])
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
`default_nettype wire

@@ sv/bqsf_checker.sv @@
// Port-level checks for the bit-quad shape feature core, bound to the top level.
`default_nettype none
module bqsf_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              s_axis_tlast,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [bqsf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import bqsf_pkg::*;

  // stalled result beat stays up
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // stalled result beat keeps its data
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // input backpressure only comes from a stalled result
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a stalled result");

  // a fresh result rises only after an accepted last pixel beat has passed the snapshot stage
  a_rise_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("result beat without a preceding last pixel");

endmodule

bind bit_quad_shape_features_core bqsf_checker u_bqsf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

@@ tb/tb_bit_quad_shape_features_core.sv @@
// Self-checking testbench for the bit-quad shape feature core: pixel streams against a predictor.
module tb_bit_quad_shape_features_core;
  import bqsf_pkg::*;

  localparam int MAXW          = MAX_WIDTH_DEF;
  localparam int IDLE_PCT      = 17;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_BEATS  = 1250;
  localparam int MAX_PRINTS    = 100;
  localparam longint unsigned CNT_SAT   = (64'd1 << COUNT_BITS_DEF) - 1;
  localparam longint unsigned AREA_SAT  = (64'd1 << AREA_FIELD_W) - 1;
  localparam longint unsigned PERIM_SAT = (64'd1 << PERIM_FIELD_W) - 1;
  // register indexes the block does not decode
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [OUT_TDATA_W-OUT_FIELDS_W-1:0] pad;
    logic [EULER_FIELD_W-1:0]            euler_quarters;
    logic [PERIM_FIELD_W-1:0]            perimeter_q16;
    logic [AREA_FIELD_W-1:0]             area_eighths;
    logic [CNT_FIELD_W-1:0]              count_diagonal;
    logic [CNT_FIELD_W-1:0]              count_four;
    logic [CNT_FIELD_W-1:0]              count_three;
    logic [CNT_FIELD_W-1:0]              count_two_adjacent;
    logic [CNT_FIELD_W-1:0]              count_one;
  } quad_result_t;

  typedef enum logic [1:0] {ROW_PIXEL, ROW_WIDTH, ROW_THRESH} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_DATA_W-1:0] value;
    logic                  last;
    logic                  typed;
    quad_result_t          want;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] pixel
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // counts, area, perimeter, euler, pad

  bit                     line_dark [MAXW];
  bit                     left_dark_m;
  bit                     upleft_dark_m;
  bit                     past_row_m;
  int unsigned            col_m;
  longint unsigned        quad_cnt [Q_NUM];
  logic [ROW_WIDTH_W-1:0] width_m;
  logic [PIXEL_W-1:0]     thresh_m;

  quad_result_t pending_features [$];
  int unsigned  beats_sent   = 0;
  int unsigned  mismatch_cnt = 0;
  int           tx_idle_pct  = IDLE_PCT;
  int           rx_idle_pct  = IDLE_PCT;
  int           sink_hold    = 0;

  bit_quad_shape_features_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int unsigned eff_width(input logic [ROW_WIDTH_W-1:0] w);
    if (w < 2) return 2;
    if (w > MAXW) return MAXW;
    return w;
  endfunction

  function automatic void clear_region_model();
    left_dark_m   = 1'b0;
    upleft_dark_m = 1'b0;
    past_row_m    = 1'b0;
    col_m         = 0;
    foreach (quad_cnt[k]) quad_cnt[k] = 0;
  endfunction

  function automatic void bump_quad(input int k);
    if (quad_cnt[k] < CNT_SAT) quad_cnt[k]++;
  endfunction

  // Advances the predictor by one pixel; returns 1 with the features on the last pixel.
  function automatic bit predict_features(input logic [PIXEL_W-1:0] px, input logic lst,
                                          output quad_result_t res);
    int unsigned     w;
    int unsigned     col;
    int unsigned     n;
    bit              d;
    bit              up;
    longint unsigned area;
    longint unsigned perim;
    longint          eul;
    w   = eff_width(width_m);
    col = (col_m >= MAXW) ? 0 : col_m;
    d   = (px <= thresh_m);
    up  = line_dark[col];
    res = '0;
    if (past_row_m && col > 0) begin
      n = int'(upleft_dark_m) + int'(up) + int'(left_dark_m) + int'(d);
      case (n)
        1: bump_quad(Q_ONE);
        2: bump_quad((upleft_dark_m == d) ? Q_DIAG : Q_TWO);
        3: bump_quad(Q_THREE);
        4: bump_quad(Q_FOUR);
        default: ;
      endcase
    end
    line_dark[col] = d;
    upleft_dark_m  = up;
    left_dark_m    = d;
    col++;
    if (col >= w) begin
      col        = 0;
      past_row_m = 1'b1;
    end
    col_m = col;
    if (!lst) return 1'b0;

    area  = 2 * quad_cnt[Q_ONE] + 4 * quad_cnt[Q_TWO] + 7 * quad_cnt[Q_THREE]
            + 8 * quad_cnt[Q_FOUR] + 6 * quad_cnt[Q_DIAG];
    perim = (quad_cnt[Q_TWO] << FRAC_BITS)
            + (quad_cnt[Q_ONE] + quad_cnt[Q_THREE] + 2 * quad_cnt[Q_DIAG]) * INV_SQRT2_Q16;
    eul   = longint'(quad_cnt[Q_ONE]) - longint'(quad_cnt[Q_THREE])
            - 2 * longint'(quad_cnt[Q_DIAG]);
    if (area > AREA_SAT) area = AREA_SAT;
    if (perim > PERIM_SAT) perim = PERIM_SAT;
    if (eul > EULER_MAX) eul = EULER_MAX;
    if (eul < EULER_MIN) eul = EULER_MIN;
    res.count_one          = CNT_FIELD_W'(quad_cnt[Q_ONE]);
    res.count_two_adjacent = CNT_FIELD_W'(quad_cnt[Q_TWO]);
    res.count_three        = CNT_FIELD_W'(quad_cnt[Q_THREE]);
    res.count_four         = CNT_FIELD_W'(quad_cnt[Q_FOUR]);
    res.count_diagonal     = CNT_FIELD_W'(quad_cnt[Q_DIAG]);
    res.area_eighths       = AREA_FIELD_W'(area);
    res.perimeter_q16      = PERIM_FIELD_W'(perim);
    res.euler_quarters     = eul[EULER_FIELD_W-1:0];
    clear_region_model();
    return 1'b1;
  endfunction

  function automatic quad_result_t make_result(input int c1, c2, c3, c4, cd, area,
                                               input longint perim, input longint eul);
    make_result                    = '0;
    make_result.count_one          = CNT_FIELD_W'(c1);
    make_result.count_two_adjacent = CNT_FIELD_W'(c2);
    make_result.count_three        = CNT_FIELD_W'(c3);
    make_result.count_four         = CNT_FIELD_W'(c4);
    make_result.count_diagonal     = CNT_FIELD_W'(cd);
    make_result.area_eighths       = AREA_FIELD_W'(area);
    make_result.perimeter_q16      = PERIM_FIELD_W'(perim);
    make_result.euler_quarters     = eul[EULER_FIELD_W-1:0];
  endfunction

  function automatic stim_row_t pix_row(input int px, input bit lst);
    pix_row       = '0;
    pix_row.kind  = ROW_PIXEL;
    pix_row.value = CFG_DATA_W'(px);
    pix_row.last  = lst;
  endfunction

  function automatic stim_row_t checked_row(input int px, input quad_result_t want);
    checked_row       = pix_row(px, 1'b1);
    checked_row.typed = 1'b1;
    checked_row.want  = want;
  endfunction

  function automatic stim_row_t cfg_row(input row_kind_e kind, input int value);
    cfg_row       = '0;
    cfg_row.kind  = kind;
    cfg_row.value = CFG_DATA_W'(value);
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_features(input quad_result_t got, input quad_result_t want);
    if (got.count_one !== want.count_one)
      report_mismatch("count_one", got.count_one, want.count_one);
    if (got.count_two_adjacent !== want.count_two_adjacent)
      report_mismatch("count_two_adjacent", got.count_two_adjacent, want.count_two_adjacent);
    if (got.count_three !== want.count_three)
      report_mismatch("count_three", got.count_three, want.count_three);
    if (got.count_four !== want.count_four)
      report_mismatch("count_four", got.count_four, want.count_four);
    if (got.count_diagonal !== want.count_diagonal)
      report_mismatch("count_diagonal", got.count_diagonal, want.count_diagonal);
    if (got.area_eighths !== want.area_eighths)
      report_mismatch("area_eighths", got.area_eighths, want.area_eighths);
    if (got.perimeter_q16 !== want.perimeter_q16)
      report_mismatch("perimeter_q16", got.perimeter_q16, want.perimeter_q16);
    if (got.euler_quarters !== want.euler_quarters)
      report_mismatch("euler_quarters", got.euler_quarters, want.euler_quarters);
    if (got.pad !== want.pad)
      report_mismatch("tdata pad bits", got.pad, want.pad);
  endtask

  // Result sink: checks each beat against the oldest expectation, stalls at random.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
        if (pending_features.size() == 0)
          report_mismatch("unexpected result beat, count_one", m_axis_tdata[CNT_FIELD_W-1:0], 0);
        else
          check_features(m_axis_tdata, pending_features.pop_front());
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_beat(input logic [PIXEL_W-1:0] px, input logic lst,
                           input bit use_typed, input quad_result_t typed);
    quad_result_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tlast  <= lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (predict_features(px, lst, pred))
      pending_features.push_back(use_typed ? typed : pred);
    beats_sent++;
  endtask

  task automatic wait_drained();
    while (pending_features.size() != 0) @(posedge clk_i);
  endtask

  // Registers change only with nothing in flight; the settle covers the two result stages.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (addr)
      CFG_ROW_WIDTH:      width_m  = data;
      CFG_DARK_THRESHOLD: thresh_m = data[PIXEL_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [PIXEL_W-1:0] pick_pixel(input int dens, input bit noisy);
    if (noisy || thresh_m == 8'hFF) return PIXEL_W'($urandom_range(255));
    if ($urandom_range(99) < dens) return PIXEL_W'($urandom_range(thresh_m, 0));
    return PIXEL_W'($urandom_range(255, thresh_m + 1));
  endfunction

  function automatic int pick_region_len(input int unsigned w);
    if ($urandom_range(9) == 0) return $urandom_range(2 * w + 3, 1);  // last lands anywhere
    if (w > 48) return w + $urandom_range(48, 1);
    return w * $urandom_range((96 / w > 2) ? 96 / w : 2, 2);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_width();
    int r;
    r = $urandom_range(99);
    if (r < 8) return CFG_DATA_W'($urandom_range(1));
    if (r < 13) return CFG_DATA_W'($urandom_range(1023, MAXW + 1));
    if (r < 16) return CFG_DATA_W'(MAXW);
    return CFG_DATA_W'($urandom_range(24, 2));
  endfunction

  // One region; with split set, the width (and maybe threshold) changes halfway.
  task automatic send_region(input int len, input bit split);
    int dens;
    bit noisy;
    int cut;
    dens  = $urandom_range(100);
    noisy = ($urandom_range(7) == 0);
    cut   = split ? len / 2 : -1;
    for (int i = 0; i < len; i++) begin
      if (i == cut) begin
        write_reg(CFG_ROW_WIDTH, CFG_DATA_W'($urandom_range(24, 2)));
        if ($urandom_range(1))
          write_reg(CFG_DARK_THRESHOLD, CFG_DATA_W'($urandom_range(255)));
      end
      send_beat(pick_pixel(dens, noisy), i == len - 1, 1'b0, '0);
    end
  endtask

  initial begin
    stim_row_t             dir_rows [$];
    int unsigned           target;
    int unsigned           phase_end;
    int                    phase;
    int                    r;
    logic [CFG_DATA_W-1:0] thr_word;

    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_addr_i    <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    width_m  = ROW_WIDTH_RST;
    thresh_m = DARK_THRESHOLD_RST;
    foreach (line_dark[k]) line_dark[k] = 1'b0;
    clear_region_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone pixel after reset: still in the first row, nothing counted
    dir_rows.push_back(checked_row(0, make_result(0, 0, 0, 0, 0, 0, 0, 0)));
    // width below range acts as 2
    dir_rows.push_back(cfg_row(ROW_WIDTH, 0));
    dir_rows.push_back(pix_row(0, 0));
    dir_rows.push_back(pix_row(0, 0));
    dir_rows.push_back(pix_row(0, 0));
    dir_rows.push_back(checked_row(0, make_result(0, 0, 0, 1, 0, 8, 0, 0)));
    // single dark pixel sitting exactly at the threshold
    dir_rows.push_back(pix_row(255, 0));
    dir_rows.push_back(pix_row(255, 0));
    dir_rows.push_back(pix_row(255, 0));
    dir_rows.push_back(checked_row(50, make_result(1, 0, 0, 0, 0, 2, 46341, 1)));
    // diagonal pair
    dir_rows.push_back(cfg_row(ROW_THRESH, 0));
    dir_rows.push_back(pix_row(0, 0));
    dir_rows.push_back(pix_row(1, 0));
    dir_rows.push_back(pix_row(1, 0));
    dir_rows.push_back(checked_row(0, make_result(0, 0, 0, 0, 1, 6, 92682, -2)));
    // threshold 255 with the spare data bits set, width above range
    dir_rows.push_back(cfg_row(ROW_THRESH, 10'h3FF));
    dir_rows.push_back(cfg_row(ROW_WIDTH, 10'h3FF));
    dir_rows.push_back(pix_row(255, 0));
    dir_rows.push_back(pix_row(128, 1));
    // three rows of three: three-dark, one-dark and adjacent-pair windows
    dir_rows.push_back(cfg_row(ROW_WIDTH, 3));
    dir_rows.push_back(cfg_row(ROW_THRESH, 127));
    dir_rows.push_back(pix_row(0, 0));
    dir_rows.push_back(pix_row(0, 0));
    dir_rows.push_back(pix_row(200, 0));
    dir_rows.push_back(pix_row(0, 0));
    dir_rows.push_back(pix_row(200, 0));
    dir_rows.push_back(pix_row(200, 0));
    dir_rows.push_back(pix_row(0, 0));
    dir_rows.push_back(pix_row(0, 0));
    dir_rows.push_back(pix_row(0, 1));

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_PIXEL:  send_beat(dir_rows[i].value[PIXEL_W-1:0], dir_rows[i].last,
                              dir_rows[i].typed, dir_rows[i].want);
        ROW_WIDTH:  write_reg(CFG_ROW_WIDTH, dir_rows[i].value);
        ROW_THRESH: write_reg(CFG_DARK_THRESHOLD, dir_rows[i].value);
        default: ;
      endcase
    end

    write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));

    // tiny regions into a stalled sink: both result stages fill and the input backs up
    write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(2));
    sink_hold = 300;
    repeat (12) send_region(4, 1'b0);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    target = beats_sent + RANDOM_BEATS;
    phase  = 0;
    while (beats_sent < target) begin
      write_reg(CFG_ROW_WIDTH, pick_width());
      thr_word = CFG_DATA_W'($urandom);
      r = $urandom_range(9);
      thr_word[PIXEL_W-1:0] = (r == 0) ? 8'd0 : (r == 1) ? 8'hFF : 8'($urandom);
      write_reg(CFG_DARK_THRESHOLD, thr_word);
      tx_idle_pct = (phase == 3) ? 0 : IDLE_PCT;
      rx_idle_pct = tx_idle_pct;
      phase_end = beats_sent + $urandom_range(140, 60);
      while (beats_sent < phase_end)
        send_region(pick_region_len(eff_width(width_m)), $urandom_range(9) == 0);
      phase++;
    end
    rx_idle_pct = IDLE_PCT;

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ bit_quad_shape_features_core.f @@
sv/bqsf_pkg.sv
sv/bit_quad_shape_features_core.sv
sv/bqsf_checker.sv
tb/tb_bit_quad_shape_features_core.sv
